/* sv/rdds_pkg.sv */
// rdds_pkg: shared types and constants for the ring dma descriptor split core
// used by rdds_mod_unit, rdds_desc_out and ring_dma_descriptor_split_core
// no dependencies
package rdds_pkg;

   localparam logic [31:0] SYS_WINDOW       = 32'h0400_0000;
   localparam logic [31:0] LOCAL_TAG        = 32'h0100_0000;
   localparam logic [31:0] LOCAL_MASK_RESET = 32'h0FFF_FFFF;

   localparam int unsigned CsrIndexWidth = 3;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_DIRECTION    = 3'd0,
      CSR_LOCAL_BASE   = 3'd1,
      CSR_LOCAL_SIZE   = 3'd2,
      CSR_SYSTEM_SIZE  = 3'd3,
      CSR_SYSTEM_OFFS  = 3'd4,
      CSR_LOCAL_MASK   = 3'd5
   } csr_index_type;

   // command codes on the request channel
   typedef enum logic {
      CMD_ADVANCE = 1'b0,
      CMD_REINIT  = 1'b1
   } command_type;

   // transfer directions
   typedef enum logic {
      DIR_PLAYBACK = 1'b0,
      DIR_CAPTURE  = 1'b1
   } direction_type;

   // request to the shared remainder unit
   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } mod_req_type;

   // status of the shared remainder unit
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] remainder;
   } mod_rsp_type;

   // one descriptor
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [23:0] cnt;
   } desc_type;

   // hand-off of one period's descriptors to the output stage
   typedef struct packed {
      logic     load;
      logic     split;
      desc_type first;
      desc_type second;
   } desc_load_type;

endpackage

/* sv/rdds_mod_unit.sv */
// rdds_mod_unit: iterative restoring remainder unit, one quotient bit per cycle
// depends on rdds_pkg (mod_req_type, mod_rsp_type)
module rdds_mod_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  rdds_pkg::mod_req_type mod_req,
   output rdds_pkg::mod_rsp_type mod_rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  count_ff;
   logic [31:0] dividend_ff;
   logic [31:0] divisor_ff;
   logic [31:0] rem_ff;

   logic [32:0] trial;
   logic [33:0] diff;
   logic [31:0] rem_in;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial = {rem_ff, dividend_ff[31]};
      diff  = {1'b0, trial} - {2'b00, divisor_ff};
      if (!diff[33]) begin
         rem_in = diff[31:0];
      end else begin
         rem_in = trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (busy_ff) begin
            count_ff <= count_ff + 5'd1;
            if (count_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end else if (mod_req.start) begin
            count_ff <= '0;
            if (mod_req.divisor == '0) begin
               // zero ring size leaves the value unreduced
               done_ff <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rem_ff      <= rem_in;
         dividend_ff <= {dividend_ff[30:0], 1'b0};
      end else if (mod_req.start) begin
         divisor_ff  <= mod_req.divisor;
         dividend_ff <= mod_req.dividend;
         if (mod_req.divisor == '0) begin
            rem_ff <= mod_req.dividend;
         end else begin
            rem_ff <= '0;
         end
      end
   end

   assign mod_rsp.busy      = busy_ff;
   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff;

endmodule

/* sv/rdds_desc_out.sv */
// rdds_desc_out: result register plus holding slot for the second descriptor
// depends on rdds_pkg (desc_type, desc_load_type)
module rdds_desc_out (
   input  logic                   clock,
   input  logic                   reset,
   input  rdds_pkg::desc_load_type desc_load,
   output logic                   out_free,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [31:0]            rsp_source_address,
   output logic [31:0]            rsp_destination_address,
   output logic [23:0]            rsp_transfer_count,
   output logic                   rsp_descriptor_slot,
   output logic [1:0]             rsp_descriptor_total,
   output logic                   rsp_last_descriptor
);

   logic               rsp_valid_ff;
   logic               hold_valid_ff;
   rdds_pkg::desc_type rsp_desc_ff;
   rdds_pkg::desc_type hold_desc_ff;
   logic               slot_ff;
   logic [1:0]         total_ff;
   logic               last_ff;
   logic               rsp_taken;

   assign rsp_taken = rsp_valid_ff && !rsp_stall;
   assign out_free  = !hold_valid_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else if (desc_load.load) begin
         rsp_valid_ff  <= 1'b1;
         hold_valid_ff <= desc_load.split;
      end else if (rsp_taken) begin
         rsp_valid_ff  <= hold_valid_ff;
         hold_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (desc_load.load) begin
         rsp_desc_ff  <= desc_load.first;
         hold_desc_ff <= desc_load.second;
         slot_ff      <= 1'b0;
         total_ff     <= desc_load.split ? 2'd2 : 2'd1;
         last_ff      <= !desc_load.split;
      end else if (rsp_taken && hold_valid_ff) begin
         rsp_desc_ff <= hold_desc_ff;
         slot_ff     <= 1'b1;
         total_ff    <= 2'd2;
         last_ff     <= 1'b1;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_source_address      = rsp_desc_ff.src;
   assign rsp_destination_address = rsp_desc_ff.dst;
   assign rsp_transfer_count      = rsp_desc_ff.cnt;
   assign rsp_descriptor_slot     = slot_ff;
   assign rsp_descriptor_total    = total_ff;
   assign rsp_last_descriptor     = last_ff;

endmodule

/* sv/ring_dma_descriptor_split_core.sv */
// ring_dma_descriptor_split_core: top level, sequencer, config and position registers
// depends on rdds_pkg, rdds_mod_unit, rdds_desc_out
//
// usage
//  - req channel (req_valid / req_stall): one transfer per period, req_command
//    advance with req_byte_count, or reinit which loads the start positions
//  - rsp channel (rsp_valid / rsp_stall): one or two descriptors per advance,
//    slot 0 first; a period that crosses the system ring end gives tail, head
//  - csr channel (csr_valid / csr_ready): register writes, always ready; the user
//    must see they are written only while the block is idle, as the block does
//    not enforce it; indexes beyond the list are dropped
//  - advance: S_SETUP, S_ADDR, then S_LOAD loads the descriptors when the output is
//    free; the input is freed after two 32-step passes through the shared remainder
//    unit (system then local ring position), a zero ring size skipping its pass
//  - req_stall is high for the whole advance; the result register and its
//    holding slot let the remainder passes run while the receiver stalls,
//    and descriptor loading waits only if an earlier one is still pending
//  - reset (synchronous, active high) clears positions to zero, loads the
//    register reset values and drops any pending descriptors
module ring_dma_descriptor_split_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [23:0] req_byte_count,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_source_address,
   output logic [31:0] rsp_destination_address,
   output logic [23:0] rsp_transfer_count,
   output logic        rsp_descriptor_slot,
   output logic [1:0]  rsp_descriptor_total,
   output logic        rsp_last_descriptor,
   // configuration channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [rdds_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [31:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_ADDR,
      S_LOAD,
      S_SYS_WAIT,
      S_LOC_WAIT
   } state_type;

   state_type state_ff;

   // configuration registers
   rdds_pkg::direction_type direction_ff;
   logic [31:0] local_base_ff;
   logic [23:0] local_size_ff;
   logic [31:0] system_size_ff;
   logic [31:0] system_offset_ff;
   logic [31:0] local_mask_ff;

   // ring positions
   logic [31:0] read_pos_ff;
   logic [31:0] write_pos_ff;

   // per-period working registers
   logic [23:0] bytes_ff;
   logic [31:0] ring_start_ff;
   logic [31:0] loc_sum_ff;
   logic        split_ff;
   logic [31:0] tail_ff;
   logic [31:0] head_ff;
   logic [31:0] sys_sum_ff;
   logic [31:0] loc_next_ff;
   logic [31:0] sys_addr_ff;
   logic [31:0] loc_addr_ff;
   logic [31:0] loc2_addr_ff;

   logic [31:0] sys_pos;
   logic [31:0] loc_pos;
   logic [31:0] bytes_ext;
   logic [31:0] loc_masked;
   logic        req_taken;
   logic        out_free;

   rdds_pkg::mod_req_type   mod_req;
   rdds_pkg::mod_rsp_type   mod_rsp;
   rdds_pkg::desc_load_type desc_load;
   rdds_pkg::desc_type      sys_side_first;
   rdds_pkg::desc_type      sys_side_second;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign req_taken = req_valid && !req_stall;

   // the system position is read in playback and write in capture
   assign sys_pos   = (direction_ff == rdds_pkg::DIR_PLAYBACK) ? read_pos_ff : write_pos_ff;
   assign loc_pos   = (direction_ff == rdds_pkg::DIR_PLAYBACK) ? write_pos_ff : read_pos_ff;
   assign bytes_ext = {8'd0, bytes_ff};
   assign loc_masked = loc_sum_ff & local_mask_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff     <= rdds_pkg::DIR_PLAYBACK;
         local_base_ff    <= '0;
         local_size_ff    <= 24'd1;
         system_size_ff   <= 32'd1;
         system_offset_ff <= '0;
         local_mask_ff    <= rdds_pkg::LOCAL_MASK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rdds_pkg::CSR_DIRECTION: begin
               direction_ff <= rdds_pkg::direction_type'(csr_data[0]);
            end
            rdds_pkg::CSR_LOCAL_BASE:  local_base_ff    <= csr_data;
            rdds_pkg::CSR_LOCAL_SIZE:  local_size_ff    <= csr_data[23:0];
            rdds_pkg::CSR_SYSTEM_SIZE: system_size_ff   <= csr_data;
            rdds_pkg::CSR_SYSTEM_OFFS: system_offset_ff <= csr_data;
            rdds_pkg::CSR_LOCAL_MASK:  local_mask_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // descriptors in playback order (system side is source)
   always_comb begin
      sys_side_first.src  = sys_addr_ff;
      sys_side_first.dst  = loc_addr_ff;
      sys_side_first.cnt  = split_ff ? tail_ff[23:0] : bytes_ff;
      sys_side_second.src = ring_start_ff;
      sys_side_second.dst = loc2_addr_ff;
      sys_side_second.cnt = head_ff[23:0];

      desc_load.load  = (state_ff == S_LOAD) && out_free;
      desc_load.split = split_ff;
      if (direction_ff == rdds_pkg::DIR_PLAYBACK) begin
         desc_load.first  = sys_side_first;
         desc_load.second = sys_side_second;
      end else begin
         // capture swaps source and destination
         desc_load.first.src  = sys_side_first.dst;
         desc_load.first.dst  = sys_side_first.src;
         desc_load.first.cnt  = sys_side_first.cnt;
         desc_load.second.src = sys_side_second.dst;
         desc_load.second.dst = sys_side_second.src;
         desc_load.second.cnt = sys_side_second.cnt;
      end
   end

   // shared remainder unit: system position first, then local position
   always_comb begin
      mod_req.start    = 1'b0;
      mod_req.dividend = split_ff ? head_ff : sys_sum_ff;
      mod_req.divisor  = system_size_ff;
      if (state_ff == S_LOAD) begin
         mod_req.start = out_free;
      end else if (state_ff == S_SYS_WAIT) begin
         mod_req.start    = mod_rsp.done;
         mod_req.dividend = loc_next_ff;
         mod_req.divisor  = {8'd0, local_size_ff};
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         read_pos_ff  <= '0;
         write_pos_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_taken) begin
                  if (req_command == rdds_pkg::CMD_REINIT) begin
                     // reinit loads the local ring size into the producer position
                     if (direction_ff == rdds_pkg::DIR_PLAYBACK) begin
                        read_pos_ff  <= {8'd0, local_size_ff};
                        write_pos_ff <= '0;
                     end else begin
                        write_pos_ff <= {8'd0, local_size_ff};
                        read_pos_ff  <= '0;
                     end
                  end else begin
                     state_ff <= S_SETUP;
                  end
               end
            end
            S_SETUP:  state_ff <= S_ADDR;
            S_ADDR:   state_ff <= S_LOAD;
            S_LOAD: begin
               if (out_free) begin
                  state_ff <= S_SYS_WAIT;
               end
            end
            S_SYS_WAIT: begin
               if (mod_rsp.done) begin
                  if (direction_ff == rdds_pkg::DIR_PLAYBACK) begin
                     read_pos_ff <= mod_rsp.remainder;
                  end else begin
                     write_pos_ff <= mod_rsp.remainder;
                  end
                  state_ff <= S_LOC_WAIT;
               end
            end
            S_LOC_WAIT: begin
               if (mod_rsp.done) begin
                  if (direction_ff == rdds_pkg::DIR_PLAYBACK) begin
                     write_pos_ff <= mod_rsp.remainder;
                  end else begin
                     read_pos_ff <= mod_rsp.remainder;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // per-period datapath, one add stage per step
   always_ff @(posedge clock) begin
      if (req_taken) begin
         bytes_ff <= req_byte_count;
      end
      if (state_ff == S_SETUP) begin
         ring_start_ff <= rdds_pkg::SYS_WINDOW + system_offset_ff;
         loc_sum_ff    <= local_base_ff + loc_pos;
         // wrap test in 33 bits so the sum cannot overflow
         split_ff      <= ({1'b0, sys_pos} + {9'd0, bytes_ff}) > {1'b0, system_size_ff};
         tail_ff       <= system_size_ff - sys_pos;
         sys_sum_ff    <= sys_pos + bytes_ext;
         loc_next_ff   <= loc_pos + bytes_ext;
      end
      if (state_ff == S_ADDR) begin
         sys_addr_ff  <= ring_start_ff + sys_pos;
         loc_addr_ff  <= loc_masked | rdds_pkg::LOCAL_TAG;
         loc2_addr_ff <= ((loc_masked + tail_ff) & local_mask_ff) | rdds_pkg::LOCAL_TAG;
         head_ff      <= bytes_ext - tail_ff;
      end
   end

   rdds_mod_unit u_mod_unit (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   rdds_desc_out u_desc_out (
      .clock                   (clock),
      .reset                   (reset),
      .desc_load               (desc_load),
      .out_free                (out_free),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_source_address      (rsp_source_address),
      .rsp_destination_address (rsp_destination_address),
      .rsp_transfer_count      (rsp_transfer_count),
      .rsp_descriptor_slot     (rsp_descriptor_slot),
      .rsp_descriptor_total    (rsp_descriptor_total),
      .rsp_last_descriptor     (rsp_last_descriptor)
   );

   // last flag matches slot and total
   a_last_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_descriptor == (rsp_descriptor_slot == (rsp_descriptor_total - 2'd1))))
      else $error("last_descriptor does not match slot and total");

   // remainder unit is only started when idle
   a_mod_start_idle: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |-> !mod_rsp.busy)
      else $error("remainder unit started while busy");

   // reduced system position lies inside the ring
   a_sys_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SYS_WAIT && mod_rsp.done && system_size_ff != '0)
         |-> (mod_rsp.remainder < system_size_ff))
      else $error("system position not reduced below ring size");

   // no descriptor load over a stalled result
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      desc_load.load |-> !(rsp_valid && rsp_stall))
      else $error("descriptor load over a stalled result");

endmodule

/* bench/ring_dma_descriptor_split_core_tb.sv */
`timescale 1ns / 1ps
// ring_dma_descriptor_split_core_tb: self-checking bench for the ring dma descriptor split core
// depends on rdds_pkg and ring_dma_descriptor_split_core
module ring_dma_descriptor_split_core_tb;

   localparam int          SETTLE_CYCLES = 100;      // covers the two remainder passes
   localparam int          MAX_REPORTS   = 10;
   localparam int          HOLD_CYCLES   = 400;
   localparam int          PHASE_ITEMS   = 170;
   localparam int          PHASE_COUNT   = 8;
   localparam int          MAX_GAP       = 60;
   localparam longint      RUN_LIMIT_NS  = 20_000_000;
   // indexes past the register list, the core drops them
   localparam logic [rdds_pkg::CsrIndexWidth-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [rdds_pkg::CsrIndexWidth-1:0] CSR_SPARE_B = 3'd7;

   // idling mix of a random phase
   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_IDLE,
      FLOW_RECEIVER_STALL,
      FLOW_BOTH
   } flow_mode_type;

   // one expected descriptor
   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [23:0] count;
      logic        slot;
      logic [1:0]  total;
      logic        last;
   } descriptor_entry_type;

   // dut ports; the inputs are known from time zero
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_command    = 1'b0;
   logic [23:0] req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [31:0] rsp_source_address;
   logic [31:0] rsp_destination_address;
   logic [23:0] rsp_transfer_count;
   logic        rsp_descriptor_slot;
   logic [1:0]  rsp_descriptor_total;
   logic        rsp_last_descriptor;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [rdds_pkg::CsrIndexWidth-1:0] csr_index = '0;
   logic [31:0] csr_data       = '0;

   // shadow of the register file and ring positions
   rdds_pkg::direction_type direction_cfg;
   logic [31:0]   local_base_cfg;
   logic [23:0]   local_size_cfg;
   logic [31:0]   system_size_cfg;
   logic [31:0]   system_offset_cfg;
   logic [31:0]   local_mask_cfg;
   logic [31:0]   read_pos;
   logic [31:0]   write_pos;

   descriptor_entry_type pending_descriptors[$];

   // run statistics
   int mismatch_count = 0;
   int checked_count  = 0;
   int advance_count  = 0;
   int reinit_count   = 0;
   int split_count    = 0;

   // idling knobs, percent per cycle
   int idle_pct  = 0;
   int stall_pct = 0;

   // long receiver hold-off, requested by a test and counted by the receiver
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   ring_dma_descriptor_split_core dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_byte_count          (req_byte_count),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_source_address      (rsp_source_address),
      .rsp_destination_address (rsp_destination_address),
      .rsp_transfer_count      (rsp_transfer_count),
      .rsp_descriptor_slot     (rsp_descriptor_slot),
      .rsp_descriptor_total    (rsp_descriptor_total),
      .rsp_last_descriptor     (rsp_last_descriptor),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // descriptor prediction
   // ------------------------------------------------------------------

   // position reduction, a zero ring size leaves the position as it is
   function automatic logic [31:0] ring_wrap(logic [31:0] value, logic [31:0] size);
      return (size == '0) ? value : value % size;
   endfunction

   function automatic void push_descriptor(logic [31:0] src, logic [31:0] dst,
                                           logic [31:0] length, int slot, int total);
      descriptor_entry_type entry;
      entry.src   = src;
      entry.dst   = dst;
      entry.count = length[23:0];   // count field keeps the low 24 bits only
      entry.slot  = slot[0];
      entry.total = total[1:0];
      entry.last  = (slot == total - 1);
      pending_descriptors.push_back(entry);
   endfunction

   // updates the shadow positions and queues the descriptors of one period
   function automatic void predict_period(rdds_pkg::command_type cmd, logic [23:0] count);
      logic [31:0] sys_pos, loc_pos, ring_start, sys_addr, loc_masked, loc_addr;
      logic [31:0] head_addr, tail_len, head_len, bytes;
      logic [32:0] reach;
      if (cmd == rdds_pkg::CMD_REINIT) begin
         // reinit loads the start positions and gives no descriptor
         reinit_count++;
         if (direction_cfg == rdds_pkg::DIR_PLAYBACK) begin
            read_pos  = {8'h00, local_size_cfg};
            write_pos = '0;
         end else begin
            write_pos = {8'h00, local_size_cfg};
            read_pos  = '0;
         end
         return;
      end
      advance_count++;
      bytes      = {8'h00, count};
      sys_pos    = (direction_cfg == rdds_pkg::DIR_PLAYBACK) ? read_pos : write_pos;
      loc_pos    = (direction_cfg == rdds_pkg::DIR_PLAYBACK) ? write_pos : read_pos;
      ring_start = rdds_pkg::SYS_WINDOW + system_offset_cfg;
      sys_addr   = ring_start + sys_pos;
      loc_masked = (local_base_cfg + loc_pos) & local_mask_cfg;
      loc_addr   = loc_masked | rdds_pkg::LOCAL_TAG;
      // end of ring test without overflow
      reach      = {1'b0, sys_pos} + {1'b0, bytes};
      head_len   = bytes;
      if (reach > {1'b0, system_size_cfg}) begin
         // tail up to the ring end, then head from the ring start
         split_count++;
         tail_len  = system_size_cfg - sys_pos;
         head_len  = bytes - tail_len;
         head_addr = ((loc_masked + tail_len) & local_mask_cfg) | rdds_pkg::LOCAL_TAG;
         if (direction_cfg == rdds_pkg::DIR_PLAYBACK) begin
            push_descriptor(sys_addr, loc_addr, tail_len, 0, 2);
            push_descriptor(ring_start, head_addr, head_len, 1, 2);
         end else begin
            push_descriptor(loc_addr, sys_addr, tail_len, 0, 2);
            push_descriptor(head_addr, ring_start, head_len, 1, 2);
         end
         sys_pos = '0;
      end else if (direction_cfg == rdds_pkg::DIR_PLAYBACK) begin
         push_descriptor(sys_addr, loc_addr, bytes, 0, 1);
      end else begin
         push_descriptor(loc_addr, sys_addr, bytes, 0, 1);
      end
      sys_pos = ring_wrap(sys_pos + head_len, system_size_cfg);
      loc_pos = ring_wrap(loc_pos + bytes, {8'h00, local_size_cfg});
      if (direction_cfg == rdds_pkg::DIR_PLAYBACK) begin
         read_pos  = sys_pos;
         write_pos = loc_pos;
      end else begin
         write_pos = sys_pos;
         read_pos  = loc_pos;
      end
   endfunction

   function automatic void apply_register(logic [rdds_pkg::CsrIndexWidth-1:0] index,
                                          logic [31:0] data);
      case (index)
         rdds_pkg::CSR_DIRECTION:   direction_cfg     = rdds_pkg::direction_type'(data[0]);
         rdds_pkg::CSR_LOCAL_BASE:  local_base_cfg    = data;
         rdds_pkg::CSR_LOCAL_SIZE:  local_size_cfg    = data[23:0];
         rdds_pkg::CSR_SYSTEM_SIZE: system_size_cfg   = data;
         rdds_pkg::CSR_SYSTEM_OFFS: system_offset_cfg = data;
         rdds_pkg::CSR_LOCAL_MASK:  local_mask_cfg    = data;
         default: ;   // spare indexes change nothing
      endcase
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
      end
   endfunction

   // every descriptor transfer is matched against the oldest expectation
   always @(posedge clock) begin : check_descriptors
      descriptor_entry_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_descriptors.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: descriptor with none expected, src %h dst %h count %h",
                        $realtime, rsp_source_address, rsp_destination_address,
                        rsp_transfer_count);
         end else begin
            want = pending_descriptors.pop_front();
            checked_count++;
            check_field("source_address", want.src, rsp_source_address);
            check_field("destination_address", want.dst, rsp_destination_address);
            check_field("transfer_count", {8'h00, want.count}, {8'h00, rsp_transfer_count});
            check_field("descriptor_slot", {31'h0, want.slot}, {31'h0, rsp_descriptor_slot});
            check_field("descriptor_total", {30'h0, want.total},
                        {30'h0, rsp_descriptor_total});
            check_field("last_descriptor", {31'h0, want.last}, {31'h0, rsp_last_descriptor});
         end
      end
   end

   // receiver: random stall, or a long hold-off counted down cycle by cycle
   always @(posedge clock) begin
      if (hold_requests != hold_served) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #(RUN_LIMIT_NS);
      $display("timeout with %0d descriptors still expected", pending_descriptors.size());
      $display("*** FAILED ***");
      $finish;
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // one period request; valid is left high after the transfer so that a
   // request following right away keeps it high without a glitch
   task automatic issue_period(input rdds_pkg::command_type cmd, input logic [23:0] count);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_byte_count <= count;
      do
         @(posedge clock);
      while (req_stall);
      predict_period(cmd, count);
   endtask

   // drop valid, wait for every descriptor, then let the remainder passes finish
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_descriptors.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [rdds_pkg::CsrIndexWidth-1:0] index,
                                 input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      apply_register(index, data);
      @(posedge clock);
   endtask

   task automatic load_config(input rdds_pkg::direction_type dir, input logic [31:0] base,
                              input logic [31:0] lsize, input logic [31:0] ssize,
                              input logic [31:0] offs, input logic [31:0] mask);
      write_register(rdds_pkg::CSR_DIRECTION, {31'h0, dir});
      write_register(rdds_pkg::CSR_LOCAL_BASE, base);
      write_register(rdds_pkg::CSR_LOCAL_SIZE, lsize);
      write_register(rdds_pkg::CSR_SYSTEM_SIZE, ssize);
      write_register(rdds_pkg::CSR_SYSTEM_OFFS, offs);
      write_register(rdds_pkg::CSR_LOCAL_MASK, mask);
   endtask

   // ring sizes: mostly small so wraps are common, sometimes full width or zero
   function automatic logic [31:0] pick_ring_size();
      case ($urandom_range(7))
         0, 1, 2: return $urandom_range(64, 1);
         3, 4:    return $urandom_range(65536, 1);
         5, 6:    return $urandom;
         default: return '0;
      endcase
   endfunction

   // byte counts scaled to the system ring, with full 24-bit values mixed in
   function automatic logic [23:0] pick_byte_count();
      logic [31:0] span;
      span = (system_size_cfg == '0 || system_size_cfg > 32'h00FF_FFFF)
             ? 32'h00FF_FFFF : system_size_cfg;
      case ($urandom_range(3))
         0, 1:    return 24'($urandom_range(span, 0));
         2:       return 24'($urandom_range(16, 0));
         default: return 24'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // register reset values: both rings one byte long, playback
   task automatic test_reset_defaults();
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000000);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000001);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000003);   // crosses the ring end
      issue_period(rdds_pkg::CMD_ADVANCE, 24'hFF_FFFF);
      drain_and_settle();
   endtask

   // spare indexes are ignored, then every register at its top value
   task automatic test_register_extremes();
      write_register(CSR_SPARE_A, 32'hFFFF_FFFF);
      write_register(CSR_SPARE_B, 32'h5A5A_A5A5);
      // local size write carries bits above 24 that must be dropped
      load_config(rdds_pkg::DIR_CAPTURE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
      issue_period(rdds_pkg::CMD_REINIT, 24'h000000);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'hFF_FFFF);  // address sums wrap
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h80_0000);
      drain_and_settle();
   endtask

   // playback: reinit puts the system position past the ring end
   task automatic test_playback_wrap();
      load_config(rdds_pkg::DIR_PLAYBACK, 32'h0000_1000, 32'h0000_0100, 32'h0000_0040,
                  32'h0000_0200, rdds_pkg::LOCAL_MASK_RESET);
      issue_period(rdds_pkg::CMD_REINIT, 24'h000000);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000010);   // tail length wraps below zero
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000030);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000020);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000041);
      drain_and_settle();
   endtask

   // capture: roles of the positions swap, narrow local mask
   task automatic test_capture_wrap();
      load_config(rdds_pkg::DIR_CAPTURE, 32'hFFFF_FF00, 32'h0000_0080, 32'h0000_0060,
                  32'h0000_0000, 32'h00FF_FFFF);
      issue_period(rdds_pkg::CMD_REINIT, 24'h000000);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000020);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000050);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000060);   // crosses the ring end
      drain_and_settle();
   endtask

   // zero ring sizes leave positions unreduced, zero mask, zero byte count
   task automatic test_zero_sizes();
      load_config(rdds_pkg::DIR_PLAYBACK, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000005);
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000007);
      issue_period(rdds_pkg::CMD_REINIT, 24'hFF_FFFF);   // reinit ignores the byte count
      issue_period(rdds_pkg::CMD_ADVANCE, 24'h000000);
      drain_and_settle();
   endtask

   // receiver holds off while requests keep coming, so the core backs up
   task automatic test_backpressure();
      idle_pct  = 0;
      stall_pct = 0;
      load_config(rdds_pkg::DIR_PLAYBACK, 32'h0002_0000, 32'h0000_0100, 32'h0000_0030,
                  32'h0000_0400, rdds_pkg::LOCAL_MASK_RESET);
      issue_period(rdds_pkg::CMD_REINIT, 24'h000000);
      hold_requests++;
      repeat (12) issue_period(rdds_pkg::CMD_ADVANCE, 24'($urandom_range(64, 0)));
      drain_and_settle();
   endtask

   // random phases: new settings, a reinit, then mostly advances
   task automatic test_random_phases();
      flow_mode_type mode;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         mode = flow_mode_type'(phase % 4);
         case (mode)
            FLOW_FREE:           begin idle_pct = 0;  stall_pct = 0;  end
            FLOW_SENDER_IDLE:    begin idle_pct = 87; stall_pct = 0;  end
            FLOW_RECEIVER_STALL: begin idle_pct = 0;  stall_pct = 87; end
            default:             begin idle_pct = 24; stall_pct = 24; end
         endcase
         // first and last phase sit at the size extremes
         if (phase == 0)
            load_config(rdds_pkg::DIR_PLAYBACK, 32'h0000_0000, 32'h0000_0001,
                        32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
         else if (phase == PHASE_COUNT - 1)
            load_config(rdds_pkg::DIR_CAPTURE, $urandom, 32'h00FF_FFFF, 32'hFFFF_FFFF,
                        $urandom, 32'hFFFF_FFFF);
         else
            load_config(rdds_pkg::direction_type'($urandom_range(1)), $urandom,
                        pick_ring_size(), pick_ring_size(), $urandom,
                        ($urandom_range(1) != 0) ? $urandom : rdds_pkg::LOCAL_MASK_RESET);
         issue_period(rdds_pkg::CMD_REINIT, pick_byte_count());
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // sender pauses until the pipe is empty in half of the phases
            if (item == PHASE_ITEMS / 2 && phase % 2 == 0)
               drain_and_settle();
            if ($urandom_range(99) < 5)
               issue_period(rdds_pkg::CMD_REINIT, 24'($urandom));
            else
               issue_period(rdds_pkg::CMD_ADVANCE, pick_byte_count());
         end
         drain_and_settle();
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      // shadow registers start at the reset values
      direction_cfg     = rdds_pkg::DIR_PLAYBACK;
      local_base_cfg    = '0;
      local_size_cfg    = 24'd1;
      system_size_cfg   = 32'd1;
      system_offset_cfg = '0;
      local_mask_cfg    = rdds_pkg::LOCAL_MASK_RESET;
      read_pos          = '0;
      write_pos         = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_playback_wrap();
      test_capture_wrap();
      test_zero_sizes();
      test_backpressure();
      test_random_phases();

      drain_and_settle();
      $display("checked %0d descriptors from %0d advances (%0d crossing the ring end)",
               checked_count, advance_count, split_count);
      $display("plus %0d reinits over playback, capture, zero and full-width rings",
               reinit_count);
      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
